// ===== design/dpq_pkg.sv =====
// ----------------------------------------------------------------------------
// dpq_pkg
// Shared types and constants for the per-CPU deadline priority queue.
// ----------------------------------------------------------------------------
package dpq_pkg;

  localparam int NUM_CPUS_DEF = 16;
  localparam int CPU_W        = 4;
  localparam int DL_W         = 64;

  typedef struct packed {
    logic [CPU_W-1:0] cpu;
    logic [DL_W-1:0]  deadline;
    logic             valid_req;
  } in_item_t;

  typedef struct packed {
    logic [CPU_W-1:0] first_cpu;
    logic             nonempty;
  } out_item_t;

  typedef struct packed {
    logic [DL_W-1:0]  deadline;
    logic [CPU_W-1:0] cpu;
  } entry_t;

  typedef struct packed {
    logic             remove;
    logic             insert;
    logic             mode;
    logic [CPU_W-1:0] cpu;
    logic [DL_W-1:0]  deadline;
  } cell_ctrl_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_REMOVE,
    ST_INSERT
  } state_t;

endpackage

// ===== design/dpq_cell.sv =====
// ----------------------------------------------------------------------------
// dpq_cell
// One queue slot: removes by CPU match (shift toward head) and inserts a new
// deadline (shift toward tail) using prefix chains from its neighbors.
// ----------------------------------------------------------------------------
module dpq_cell (
  input  logic                clk,
  input  dpq_pkg::cell_ctrl_t ctrl,
  input  logic                occ,
  input  dpq_pkg::entry_t     prev_entry,
  input  dpq_pkg::entry_t     next_entry,
  input  logic                hit_in,
  input  logic                stop_in,
  output dpq_pkg::entry_t     entry_out,
  output logic                hit_out,
  output logic                stop_out
);
  import dpq_pkg::*;

  entry_t entry_r;
  entry_t entry_nxt;
  entry_t new_entry;
  logic   match;
  logic   ahead;

  assign new_entry.deadline = ctrl.deadline;
  assign new_entry.cpu      = ctrl.cpu;

  assign match    = occ && (entry_r.cpu == ctrl.cpu);
  assign hit_out  = hit_in | match;
  assign ahead    = occ && (ctrl.mode ? (entry_r.deadline < ctrl.deadline)
                                      : (entry_r.deadline > ctrl.deadline));
  assign stop_out = stop_in | ~ahead;

  always_comb begin
    entry_nxt = entry_r;
    if (ctrl.remove && hit_out) begin
      entry_nxt = next_entry;
    end else if (ctrl.insert) begin
      if (stop_in) begin
        entry_nxt = prev_entry;
      end else if (!ahead) begin
        entry_nxt = new_entry;
      end
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

  assign entry_out = entry_r;

endmodule

// ===== design/per_cpu_deadline_priority_queue.sv =====
// ----------------------------------------------------------------------------
// per_cpu_deadline_priority_queue
// Sorted chain of cells, one deadline per CPU; reports the CPU at the head.
// ----------------------------------------------------------------------------
// An accepted item passes through the remove and insert states (busy is high
//   in both); out_strobe is registered from the insert state and is high back
//   in idle. No new item is taken until the queue is back in idle, where one
//   may be taken while the previous result is shown.
// Reset (synchronous, rst_n low): queue empty, order_mode 0, idle.
// The receiver cannot stall; out_strobe is high for exactly one cycle.
module per_cpu_deadline_priority_queue #(
  parameter int NUM_CPUS = dpq_pkg::NUM_CPUS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  dpq_pkg::in_item_t  in_item,
  output logic               out_strobe,
  output dpq_pkg::out_item_t out_item,
  input  logic               cfg_we,
  input  logic               cfg_wdata
);
  import dpq_pkg::*;

  localparam int CNT_W = $clog2(NUM_CPUS + 1);

  state_t             state_r;
  state_t             state_nxt;
  logic [CNT_W-1:0]   count_r;
  logic [CNT_W-1:0]   count_nxt;
  logic               mode_r;
  logic               out_strobe_r;
  in_item_t           item_r;
  logic               accept;
  logic               in_range;
  logic               remove_en;
  logic               insert_en;
  cell_ctrl_t         ctrl;
  entry_t             entries [NUM_CPUS];
  logic [NUM_CPUS:0]  hit_chain;
  logic [NUM_CPUS:0]  stop_chain;

  assign accept   = start && !busy;
  assign in_range = (int'(item_r.cpu) < NUM_CPUS);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:   if (start) state_nxt = ST_REMOVE;
      ST_REMOVE: state_nxt = ST_INSERT;
      ST_INSERT: state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    busy      = 1'b0;
    remove_en = 1'b0;
    insert_en = 1'b0;
    case (state_r)
      ST_IDLE: begin
      end
      ST_REMOVE: begin
        busy      = 1'b1;
        remove_en = in_range;
      end
      ST_INSERT: begin
        busy      = 1'b1;
        insert_en = in_range && item_r.valid_req && (count_r < CNT_W'(NUM_CPUS));
      end
      default: begin
      end
    endcase
  end

  assign ctrl.remove   = remove_en;
  assign ctrl.insert   = insert_en;
  assign ctrl.mode     = mode_r;
  assign ctrl.cpu      = item_r.cpu;
  assign ctrl.deadline = item_r.deadline;

  assign hit_chain[0]  = 1'b0;
  assign stop_chain[0] = 1'b0;

  for (genvar i = 0; i < NUM_CPUS; i++) begin : g_cell
    entry_t prev_e;
    entry_t next_e;
    if (i == 0) begin : g_head
      assign prev_e.deadline = item_r.deadline;
      assign prev_e.cpu      = item_r.cpu;
    end else begin : g_mid
      assign prev_e = entries[i-1];
    end
    if (i == NUM_CPUS - 1) begin : g_tail
      assign next_e = entries[i];
    end else begin : g_body
      assign next_e = entries[i+1];
    end
    dpq_cell u_cell (
      .clk        (clk),
      .ctrl       (ctrl),
      .occ        (count_r > CNT_W'(i)),
      .prev_entry (prev_e),
      .next_entry (next_e),
      .hit_in     (hit_chain[i]),
      .stop_in    (stop_chain[i]),
      .entry_out  (entries[i]),
      .hit_out    (hit_chain[i+1]),
      .stop_out   (stop_chain[i+1])
    );
  end

  always_comb begin
    count_nxt = count_r;
    if (remove_en && hit_chain[NUM_CPUS]) begin
      count_nxt = count_r - CNT_W'(1);
    end else if (insert_en) begin
      count_nxt = count_r + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      count_r      <= '0;
      mode_r       <= 1'b0;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      count_r      <= count_nxt;
      out_strobe_r <= (state_r == ST_INSERT);
      if (cfg_we) begin
        mode_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_r <= in_item;
    end
  end

  assign out_strobe         = out_strobe_r;
  assign out_item.nonempty  = (count_r != '0);
  assign out_item.first_cpu = (count_r != '0) ? entries[0].cpu : '0;

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the per-CPU deadline priority queue.
// Items are driven through the start/busy handshake. A scoreboard keeps its
// own sorted copy of the queue and predicts the head CPU and the nonempty flag
// for every accepted item. A directed opening covers ties, updates, removals
// and an order change with entries held. Random phases in both order modes
// follow, with random idle gaps.
// ----------------------------------------------------------------------------
module testbench;
  import dpq_pkg::*;

  localparam int NUM_CPUS  = NUM_CPUS_DEF;
  localparam int WD_LIMIT  = 1000;
  localparam int SETTLE    = 6;
  localparam bit LARGEST_FIRST  = 1'b0;
  localparam bit SMALLEST_FIRST = 1'b1;

  class deadline_scoreboard;
    entry_t      slots[NUM_CPUS];
    int unsigned depth;
    int unsigned peak_depth;
    bit          smallest_first;
    out_item_t   head_q[$];
    int unsigned mismatches;
    int unsigned results_seen;

    function new();
      depth          = 0;
      peak_depth     = 0;
      smallest_first = LARGEST_FIRST;
      mismatches     = 0;
      results_seen   = 0;
    endfunction

    function void set_order(bit m);
      smallest_first = m;
    endfunction

    function bit goes_first(logic [DL_W-1:0] a, logic [DL_W-1:0] b);
      return smallest_first ? (a < b) : (a > b);
    endfunction

    function int unsigned pending();
      return head_q.size();
    endfunction

    // apply one update to the shadow queue and queue the expected head
    function void note_item(in_item_t it);
      out_item_t   want;
      int unsigned pos;
      for (int i = 0; i < depth; i++) begin
        if (slots[i].cpu == it.cpu) begin
          for (int j = i; j + 1 < depth; j++) slots[j] = slots[j+1];
          depth--;
          break;
        end
      end
      if (it.valid_req && depth < NUM_CPUS) begin
        pos = 0;
        while (pos < depth && goes_first(slots[pos].deadline, it.deadline)) pos++;
        for (int j = depth; j > pos; j--) slots[j] = slots[j-1];
        slots[pos].deadline = it.deadline;
        slots[pos].cpu      = it.cpu;
        depth++;
      end
      if (depth > peak_depth) peak_depth = depth;
      want.nonempty  = (depth > 0);
      want.first_cpu = (depth > 0) ? slots[0].cpu : '0;
      head_q.push_back(want);
    endfunction

    task report_mismatch(string what);
      $display("mismatch @%0t: %s", $time, what);
      mismatches++;
    endtask

    task check_result(out_item_t got);
      out_item_t want;
      results_seen++;
      if (head_q.size() == 0) begin
        report_mismatch($sformatf("unexpected result first_cpu=%0d nonempty=%0b",
                                  got.first_cpu, got.nonempty));
      end else begin
        want = head_q.pop_front();
        if (got.first_cpu !== want.first_cpu)
          report_mismatch($sformatf("first_cpu got %0d want %0d",
                                    got.first_cpu, want.first_cpu));
        if (got.nonempty !== want.nonempty)
          report_mismatch($sformatf("nonempty got %0b want %0b",
                                    got.nonempty, want.nonempty));
      end
    endtask
  endclass

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      start     = 1'b0;
  logic      busy;
  in_item_t  in_item   = '0;
  logic      out_strobe;
  out_item_t out_item;
  logic      cfg_we    = 1'b0;
  logic      cfg_wdata = 1'b0;

  deadline_scoreboard sb;
  int unsigned items_sent  = 0;
  int unsigned mode_writes = 0;
  int unsigned quiet_cycles = 0;

  per_cpu_deadline_priority_queue #(
    .NUM_CPUS(NUM_CPUS)
  ) u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .out_strobe(out_strobe),
    .out_item  (out_item),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst_n && out_strobe) sb.check_result(out_item);
  end

  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_strobe) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WD_LIMIT) begin
      $display("watchdog: no item moved for %0d cycles", WD_LIMIT);
      $display("FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic in_item_t make_item(int unsigned c, logic [DL_W-1:0] dl, bit v);
    in_item_t it;
    it.cpu       = c[CPU_W-1:0];
    it.deadline  = dl;
    it.valid_req = v;
    return it;
  endfunction

  function automatic logic [DL_W-1:0] pick_deadline();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return '1;
      2:       return DL_W'($urandom_range(0, 7));
      3:       return 64'h8000_0000_0000_0000 + $urandom_range(0, 3);
      default: return {$urandom, $urandom};
    endcase
  endfunction

  task automatic send_item(in_item_t it);
    in_item <= it;
    start   <= 1'b1;
    do @(posedge clk); while (busy);
    sb.note_item(it);
    items_sent++;
  endtask

  // random gaps, except for a long stretch with none
  task automatic maybe_idle();
    if ((items_sent < 300 || items_sent >= 500) && $urandom_range(0, 99) < 10) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  task automatic write_order(bit m);
    start <= 1'b0;
    while (sb.pending() != 0 || busy) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= m;
    @(posedge clk);
    cfg_we    <= 1'b0;
    sb.set_order(m);
    mode_writes++;
  endtask

  in_item_t    directed[$];
  int unsigned valid_pct[4] = '{85, 60, 90, 40};
  bit          phase_mode[4] = '{SMALLEST_FIRST, LARGEST_FIRST, SMALLEST_FIRST, LARGEST_FIRST};

  initial begin
    sb = new();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // largest first: remove on empty, ties, updates, removals
    directed.push_back(make_item(7, '1, 1'b0));
    directed.push_back(make_item(0, '1, 1'b1));
    directed.push_back(make_item(15, '0, 1'b1));
    directed.push_back(make_item(5, '1, 1'b1));
    directed.push_back(make_item(9, 64'h5555_5555_5555_5555, 1'b1));
    directed.push_back(make_item(5, '0, 1'b0));
    directed.push_back(make_item(15, 64'hAAAA_AAAA_AAAA_AAAA, 1'b1));
    directed.push_back(make_item(10, '1, 1'b1));
    foreach (directed[i]) begin
      send_item(directed[i]);
      maybe_idle();
    end
    directed.delete();

    // smallest first with old entries left in place
    write_order(SMALLEST_FIRST);
    directed.push_back(make_item(3, '0, 1'b1));
    directed.push_back(make_item(12, 64'd1, 1'b1));
    directed.push_back(make_item(4, '0, 1'b1));
    directed.push_back(make_item(4, '1, 1'b0));
    directed.push_back(make_item(3, '0, 1'b0));
    directed.push_back(make_item(10, '0, 1'b0));
    directed.push_back(make_item(0, '0, 1'b0));
    directed.push_back(make_item(12, '0, 1'b0));
    directed.push_back(make_item(9, '0, 1'b0));
    directed.push_back(make_item(15, '0, 1'b0));
    directed.push_back(make_item(15, '0, 1'b0));
    foreach (directed[i]) begin
      send_item(directed[i]);
      maybe_idle();
    end

    for (int p = 0; p < 4; p++) begin
      write_order(phase_mode[p]);
      for (int n = 0; n < 250; n++) begin
        send_item(make_item($urandom_range(0, NUM_CPUS - 1), pick_deadline(),
                            $urandom_range(0, 99) < valid_pct[p]));
        maybe_idle();
      end
    end

    start <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);

    $display("covered %0d items and %0d results in both orders, %0d order writes",
             items_sent, sb.results_seen, mode_writes);
    $display("queue depth reached %0d of %0d", sb.peak_depth, NUM_CPUS);
    if (sb.mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("%0d mismatches", sb.mismatches);
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ===== per_cpu_deadline_priority_queue.f =====
design/dpq_pkg.sv
design/dpq_cell.sv
design/per_cpu_deadline_priority_queue.sv
bench/testbench.sv
